// ----- sv/deq_pkg.sv -----
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // port widths fixed by the interface
    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT_FRONT = 3'd0,
        OP_INSERT_BACK  = 3'd1,
        OP_REMOVE_FRONT = 3'd2,
        OP_REMOVE_BACK  = 3'd3,
        OP_PEEK_FRONT   = 3'd4,
        OP_PEEK_BACK    = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins_front;
        logic ins_back;
        logic rem_front;
        logic rem_back;
    } t_cell_ctl;

endpackage

// ----- sv/deq_cell.sv -----
module deq_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  deq_pkg::t_cell_ctl              i_ctl,
    input  logic [deq_pkg::DATA_WIDTH-1:0]  i_data_in,
    input  logic                            i_prev_valid,
    input  logic [deq_pkg::DATA_WIDTH-1:0]  i_prev_data,
    input  logic                            i_next_valid,
    input  logic [deq_pkg::DATA_WIDTH-1:0]  i_next_data,
    output logic                            o_valid,
    output logic [deq_pkg::DATA_WIDTH-1:0]  o_data,
    output logic [deq_pkg::DATA_WIDTH-1:0]  o_back_data
);

    logic                           r_valid;
    logic                           n_valid;
    logic [deq_pkg::DATA_WIDTH-1:0] r_data;
    logic [deq_pkg::DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.ins_front) begin
            // whole chain moves one cell toward the back
            n_valid = i_prev_valid;
            n_data  = i_prev_data;
        end else if (i_ctl.ins_back) begin
            // first empty cell takes the word
            if (!r_valid && i_prev_valid) begin
                n_valid = 1'b1;
                n_data  = i_data_in;
            end
        end else if (i_ctl.rem_front) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (i_ctl.rem_back) begin
            if (r_valid && !i_next_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_back_data = (r_valid && !i_next_valid) ? r_data : '0;

endmodule

// ----- sv/double_ended_queue_unit.sv -----
// The result of each accepted item is captured in the output register.
// Throughput: one item per cycle while the output register is free or drains;
// all cells update in the same cycle; the output register is the sole hand-off stage.
// Reset (synchronous, active low): clears the cell occupancy flags, the word
// count and the output valid. Stored words are not cleared.
module double_ended_queue_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [deq_pkg::OP_W-1:0]      i_op,
    input  logic [deq_pkg::WORD_W-1:0]    i_data_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [deq_pkg::STATUS_W-1:0]  o_status,
    output logic [deq_pkg::WORD_W-1:0]    o_data_out,
    output logic [deq_pkg::COUNT_W-1:0]   o_count
);

    localparam int D  = deq_pkg::DEPTH;
    localparam int DW = deq_pkg::DATA_WIDTH;

    // Storage is a chain of cells; cell 0 is always the front of the deque
    // and the occupied cells are contiguous from cell 0. A push at the front
    // shifts the chain back, a pop at the front shifts it forward, and the
    // back end is the last occupied cell, found locally by each cell.

    logic                          w_accept;
    logic [D-1:0]                  w_valid;
    logic [DW-1:0]                 w_data      [D];
    logic [DW-1:0]                 w_back_data [D];
    logic [DW-1:0]                 w_back_word;
    logic [DW-1:0]                 w_word_in;
    logic                          w_full;
    logic                          w_empty;
    deq_pkg::t_cell_ctl            w_ctl;

    logic [deq_pkg::CNT_W-1:0]     r_fill;
    logic [deq_pkg::CNT_W-1:0]     n_fill;
    logic                          r_out_valid;
    deq_pkg::t_status              r_status;
    deq_pkg::t_status              n_status;
    logic [DW-1:0]                 r_rd;
    logic [DW-1:0]                 n_rd;

    // Input side may advance whenever the output register is free or drains.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_word_in  = DW'(i_data_in);
    assign w_full     = w_valid[D-1];
    assign w_empty    = !w_valid[0];

    // Request decode: command for the chain, status, peek data, new count.
    always_comb begin
        w_ctl    = '0;
        n_status = deq_pkg::ST_OK;
        n_rd     = '0;
        n_fill   = r_fill;
        unique case (deq_pkg::t_op'(i_op))
            deq_pkg::OP_INSERT_FRONT,
            deq_pkg::OP_INSERT_BACK: begin
                if (w_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    w_ctl.ins_front = (deq_pkg::t_op'(i_op) == deq_pkg::OP_INSERT_FRONT);
                    w_ctl.ins_back  = (deq_pkg::t_op'(i_op) == deq_pkg::OP_INSERT_BACK);
                    n_fill          = r_fill + 1'b1;
                end
            end
            deq_pkg::OP_REMOVE_FRONT,
            deq_pkg::OP_REMOVE_BACK: begin
                if (w_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_ctl.rem_front = (deq_pkg::t_op'(i_op) == deq_pkg::OP_REMOVE_FRONT);
                    w_ctl.rem_back  = (deq_pkg::t_op'(i_op) == deq_pkg::OP_REMOVE_BACK);
                    n_fill          = r_fill - 1'b1;
                end
            end
            deq_pkg::OP_PEEK_FRONT: begin
                if (w_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_rd = w_data[0];
                end
            end
            deq_pkg::OP_PEEK_BACK: begin
                if (w_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_rd = w_back_word;
                end
            end
            default: begin
                // unused codes: no effect, status ok
            end
        endcase
        if (!w_accept) begin
            w_ctl = '0;
        end
    end

    // At most one cell (none when empty) flags itself as the back; OR its gated word out.
    always_comb begin
        w_back_word = '0;
        for (int i = 0; i < D; i++) begin
            w_back_word = w_back_word | w_back_data[i];
        end
    end

    for (genvar g = 0; g < D; g++) begin : g_cell
        logic          w_prev_valid;
        logic [DW-1:0] w_prev_data;
        logic          w_next_valid;
        logic [DW-1:0] w_next_data;

        if (g == 0) begin : g_head
            // front neighbor of cell 0 is the incoming word
            assign w_prev_valid = 1'b1;
            assign w_prev_data  = w_word_in;
        end else begin : g_mid
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_data  = w_data[g-1];
        end

        if (g == D - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_data  = '0;
        end else begin : g_body
            assign w_next_valid = w_valid[g+1];
            assign w_next_data  = w_data[g+1];
        end

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_data_in    (w_word_in),
            .i_prev_valid (w_prev_valid),
            .i_prev_data  (w_prev_data),
            .i_next_valid (w_next_valid),
            .i_next_data  (w_next_data),
            .o_valid      (w_valid[g]),
            .o_data       (w_data[g]),
            .o_back_data  (w_back_data[g])
        );
    end

    // Fill count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_rd     <= n_rd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data_out  = deq_pkg::WORD_W'(r_rd);
    assign o_count     = deq_pkg::COUNT_W'(r_fill);

    // Occupancy flags in the chain always agree with the count.
    a_fill_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        deq_pkg::CNT_W'($countones(w_valid)) == r_fill)
        else $error("cell occupancy disagrees with fill count");

    // Occupied cells stay packed toward the front: flags form a run of ones from bit 0.
    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + D'(1))) == '0)
        else $error("hole in occupied cell chain");

    // A read on an empty deque reports empty and leaves the count alone.
    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_empty && (i_op == deq_pkg::OP_REMOVE_FRONT
            || i_op == deq_pkg::OP_REMOVE_BACK || i_op == deq_pkg::OP_PEEK_FRONT
            || i_op == deq_pkg::OP_PEEK_BACK))
        |=> (o_status == deq_pkg::ST_EMPTY && r_fill == '0))
        else $error("empty read not reported");

endmodule
